FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, sampled on clk, off while arst_n is low.
`define SIL_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Antecedent in one cycle, consequent in the next.
`define SIL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/sil_pkg.sv
// Shared types and constants of the sorted three-list block.
package sil_pkg;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_READ   = 2'd1,
		OP_CLEAR  = 2'd2
	} op_t;

	localparam logic [1:0] SEL_MINORS = 2'd0;
	localparam logic [1:0] SEL_FEMALE = 2'd1;
	localparam logic [1:0] SEL_MALE   = 2'd2;

	localparam logic [1:0] GENDER_MALE   = 2'd1;
	localparam logic [1:0] GENDER_FEMALE = 2'd2;

	localparam logic [7:0] ADULT_AGE_RESET = 8'd20;

	// Link from one cell to its right-hand neighbor.
	typedef struct packed {
		logic       gt;
		logic [7:0] entry;
	} cell_link_t;

	// Per-list command for the current transfer.
	typedef struct packed {
		logic       ins;
		logic       clr;
		logic [7:0] age;
	} list_ctrl_t;

endpackage

FILE: hw/rtl/sil_cell.sv
// One compare-and-shift cell of a sorted list.
module sil_cell #(
	parameter int IDX = 0,
	parameter int CW  = 7
) (
	input  logic                clk,
	input  logic                ins,
	input  logic [7:0]          age,
	input  logic [CW-1:0]       count,
	input  sil_pkg::cell_link_t prev,
	output sil_pkg::cell_link_t link
);
	import sil_pkg::*;

	logic [7:0] entry_q;
	logic       occupied;
	logic       at_end;
	logic       gt;

	assign occupied = count > CW'(IDX);
	assign at_end   = count == CW'(IDX);
	assign gt       = occupied && (entry_q > age);

	assign link.gt    = gt;
	assign link.entry = entry_q;

	// Cells past the slot take their left neighbor, the slot takes the new age.
	always_ff @(posedge clk) begin
		if (ins) begin
			if (prev.gt) begin
				entry_q <= prev.entry;
			end else if (gt || at_end) begin
				entry_q <= age;
			end
		end
	end

endmodule

FILE: hw/rtl/sil_list.sv
// One bounded ascending list: a row of cells, its count and a read port.
module sil_list #(
	parameter int DEPTH = 64,
	parameter int CW    = $clog2(DEPTH + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  sil_pkg::list_ctrl_t ctrl,
	input  logic [5:0]          rd_pos,
	output logic [CW-1:0]       count,
	output logic                full,
	output logic [7:0]          rd_age,
	output logic                rd_valid
);
	import sil_pkg::*;

	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int WIDE = (CW > 6) ? CW : 6;

	cell_link_t      links [DEPTH];
	logic [7:0]      entries [DEPTH];
	logic [CW-1:0]   count_q;
	logic            ins_ok;
	logic [WIDE-1:0] pos_w;

	assign full   = count_q == CW'(DEPTH);
	assign ins_ok = ctrl.ins && !full;
	assign count  = count_q;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		cell_link_t prev;
		if (i == 0) begin : g_head
			assign prev = '0;
		end else begin : g_body
			assign prev = links[i-1];
		end
		sil_cell #(.IDX(i), .CW(CW)) u_cell (
			.clk   (clk),
			.ins   (ins_ok),
			.age   (ctrl.age),
			.count (count_q),
			.prev  (prev),
			.link  (links[i])
		);
		assign entries[i] = links[i].entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctrl.clr) begin
			count_q <= '0;
		end else if (ins_ok) begin
			count_q <= count_q + CW'(1);
		end
	end

	assign pos_w    = WIDE'(rd_pos);
	assign rd_valid = (pos_w < WIDE'(DEPTH)) && (pos_w < WIDE'(count_q));
	assign rd_age   = rd_valid ? entries[pos_w[AW-1:0]] : 8'd0;

endmodule

FILE: hw/rtl/sorted_insert_three_lists.sv
// Top level: three sorted age lists behind a stream interface.
//
// Input stream s_*: one transfer is one command. tuser carries the operation
// (insert, read, clear); tdata carries age, gender, list select and position.
// Output stream m_*: exactly one result transfer per command, in order.
// Config channel cfg_*: writes adult_age; always ready, write only when idle.
//
// Each list is a row of compare-and-shift cells; an insert lands in its slot
// in the cycle it is accepted, the cells past it shifting from their neighbors at once.
// The result is registered and valid in the cycle after the input transfer. Throughput
// is one command per cycle unless the receiver stalls; the result register sets it,
// as the lists update at the accepting edge and the next command sees the new contents.
//
// Reset empties all lists and loads adult_age with 20. Entry storage is not
// reset and needs no clearing pass. When the receiver stalls, the result
// register holds and s_tready drops until the result is taken.
module sorted_insert_three_lists #(
	parameter int LIST_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // age[7:0], gender[9:8], list_select[11:10], position[17:12]
	input  logic [1:0]  s_tuser,  // operation[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // read_age[7:0], read_valid[8], list_count[15:9], insert_refused[16]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data
);
	import sil_pkg::*;

	localparam int CW = $clog2(LIST_DEPTH + 1);

	logic       accept;
	op_t        op;
	logic [7:0] age;
	logic [1:0] gender;
	logic [1:0] list_select;
	logic [5:0] position;

	logic [7:0] adult_age_q;
	logic       out_valid_q;
	logic [23:0] out_data_q;

	list_ctrl_t ctrl_min, ctrl_fem, ctrl_male;
	logic [CW-1:0] cnt_min, cnt_fem, cnt_male;
	logic full_min, full_fem, full_male;
	logic [7:0] age_min, age_fem, age_male;
	logic val_min, val_fem, val_male;

	logic [7:0] r_age;
	logic       r_valid;
	logic [6:0] r_count;
	logic       r_refused;

	assign op          = op_t'(s_tuser);
	assign age         = s_tdata[7:0];
	assign gender      = s_tdata[9:8];
	assign list_select = s_tdata[11:10];
	assign position    = s_tdata[17:12];

	assign s_tready  = !out_valid_q || m_tready;
	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			adult_age_q <= ADULT_AGE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			adult_age_q <= cfg_data;
		end
	end

	always_comb begin
		ctrl_min      = '0;
		ctrl_fem      = '0;
		ctrl_male     = '0;
		ctrl_min.age  = age;
		ctrl_fem.age  = age;
		ctrl_male.age = age;
		if (accept) begin
			unique case (op)
				OP_INSERT: begin
					ctrl_min.ins  = age < adult_age_q;
					ctrl_male.ins = gender == GENDER_MALE;
					ctrl_fem.ins  = gender == GENDER_FEMALE;
				end
				OP_CLEAR: begin
					ctrl_min.clr  = 1'b1;
					ctrl_fem.clr  = 1'b1;
					ctrl_male.clr = 1'b1;
				end
				default: ;
			endcase
		end
	end

	sil_list #(.DEPTH(LIST_DEPTH), .CW(CW)) u_minors (
		.clk(clk), .arst_n(arst_n), .ctrl(ctrl_min), .rd_pos(position),
		.count(cnt_min), .full(full_min), .rd_age(age_min), .rd_valid(val_min)
	);
	sil_list #(.DEPTH(LIST_DEPTH), .CW(CW)) u_female (
		.clk(clk), .arst_n(arst_n), .ctrl(ctrl_fem), .rd_pos(position),
		.count(cnt_fem), .full(full_fem), .rd_age(age_fem), .rd_valid(val_fem)
	);
	sil_list #(.DEPTH(LIST_DEPTH), .CW(CW)) u_male (
		.clk(clk), .arst_n(arst_n), .ctrl(ctrl_male), .rd_pos(position),
		.count(cnt_male), .full(full_male), .rd_age(age_male), .rd_valid(val_male)
	);

	always_comb begin
		r_age     = 8'd0;
		r_valid   = 1'b0;
		r_count   = 7'd0;
		r_refused = 1'b0;
		unique case (op)
			OP_INSERT: begin
				r_refused = (ctrl_min.ins && full_min) || (ctrl_fem.ins && full_fem)
					|| (ctrl_male.ins && full_male);
			end
			OP_READ: begin
				unique case (list_select)
					SEL_MINORS: begin
						r_age   = age_min;
						r_valid = val_min;
						r_count = 7'(cnt_min);
					end
					SEL_FEMALE: begin
						r_age   = age_fem;
						r_valid = val_fem;
						r_count = 7'(cnt_fem);
					end
					SEL_MALE: begin
						r_age   = age_male;
						r_valid = val_male;
						r_count = 7'(cnt_male);
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s_tready) begin
			out_valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_data_q <= {7'd0, r_refused, r_count, r_valid, r_age};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

`include "assert_macros.svh"

	`SIL_ASSERT_NEXT(a_clear_empties, accept && s_tuser == OP_CLEAR,
		cnt_min == '0 && cnt_fem == '0 && cnt_male == '0, "clear left a list non-empty")
	`SIL_ASSERT_NEXT(a_bad_select_zero,
		accept && s_tuser == OP_READ && s_tdata[11:10] == 2'd3,
		m_tvalid && m_tdata == 24'd0, "read of unused list gave nonzero result")
	`SIL_ASSERT(a_refused_not_read, !(m_tvalid && m_tdata[16] && m_tdata[8]),
		"result flags both refused insert and valid read")
	`SIL_ASSERT(a_ready_only_on_stall, s_tready || (m_tvalid && !m_tready),
		"input stalled without a stalled result")

endmodule

FILE: test/age_list_checker.sv
// Checker for the sorted three-list block: predicts each command's result and compares.
module age_list_checker #(
	parameter int LIST_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [23:0] s_tdata,  // age[7:0], gender[9:8], list_select[11:10], position[17:12]
	input  logic [1:0]  s_tuser,  // operation[1:0]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,  // read_age[7:0], read_valid[8], list_count[15:9], insert_refused[16]
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [7:0]  cfg_data,
	output int          pending,
	output int          fail_count
);
	import sil_pkg::*;

	typedef struct packed {
		logic [7:0] age;
		logic       valid;
		logic [6:0] count;
		logic       refused;
	} age_report_t;

	// list storage indexed by list select: minors, female, male
	logic [7:0]  ages [3][LIST_DEPTH];
	int unsigned fill [3];
	logic [7:0]  adult_limit;
	age_report_t expected_reports [$];
	int          mismatches;

	// sorted insert after any equal entries; full lists are left alone
	task automatic place_age(input int lst, input logic [7:0] a, output logic full);
		int slot;
		full = (fill[lst] >= LIST_DEPTH);
		if (!full) begin
			slot = 0;
			while (slot < fill[lst] && ages[lst][slot] <= a)
				slot++;
			for (int i = fill[lst]; i > slot; i--)
				ages[lst][i] = ages[lst][i - 1];
			ages[lst][slot] = a;
			fill[lst]++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		age_report_t want;
		age_report_t got;
		logic [7:0]  in_age;
		logic [1:0]  in_gender;
		logic [1:0]  in_sel;
		logic [5:0]  in_pos;
		logic        full;
		if (!arst_n) begin
			adult_limit = ADULT_AGE_RESET;
			fill[0] = 0;
			fill[1] = 0;
			fill[2] = 0;
			expected_reports.delete();
			mismatches = 0;
			pending <= 0;
			fail_count <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				adult_limit = cfg_data;

			if (s_tvalid && s_tready) begin
				in_age    = s_tdata[7:0];
				in_gender = s_tdata[9:8];
				in_sel    = s_tdata[11:10];
				in_pos    = s_tdata[17:12];
				want = '0;
				case (s_tuser)
					OP_INSERT: begin
						if (in_age < adult_limit) begin
							place_age(SEL_MINORS, in_age, full);
							want.refused |= full;
						end
						if (in_gender == GENDER_MALE) begin
							place_age(SEL_MALE, in_age, full);
							want.refused |= full;
						end else if (in_gender == GENDER_FEMALE) begin
							place_age(SEL_FEMALE, in_age, full);
							want.refused |= full;
						end
					end
					OP_READ: begin
						if (in_sel <= SEL_MALE) begin
							want.count = 7'(fill[in_sel]);
							if (in_pos < fill[in_sel] && in_pos < LIST_DEPTH) begin
								want.valid = 1'b1;
								want.age = ages[in_sel][in_pos];
							end
						end
					end
					OP_CLEAR: begin
						fill[0] = 0;
						fill[1] = 0;
						fill[2] = 0;
					end
					default: ;
				endcase
				expected_reports.push_back(want);
			end

			if (m_tvalid && m_tready) begin
				got = '{age: m_tdata[7:0], valid: m_tdata[8], count: m_tdata[15:9],
					refused: m_tdata[16]};
				if (expected_reports.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("extra result: age %0d valid %0d count %0d refused %0d",
							got.age, got.valid, got.count, got.refused);
				end else begin
					want = expected_reports.pop_front();
					if (got.age != want.age || got.valid != want.valid ||
							got.count != want.count || got.refused != want.refused) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("mismatch: want age %0d valid %0d count %0d refused %0d",
								want.age, want.valid, want.count, want.refused);
							$display("          got  age %0d valid %0d count %0d refused %0d",
								got.age, got.valid, got.count, got.refused);
						end
					end
				end
			end

			pending <= expected_reports.size();
			fail_count <= mismatches;
		end
	end

endmodule

FILE: test/sorted_insert_three_lists_test.sv
// Testbench top for the sorted three-list block: stimulus, flow control and verdict.
module sorted_insert_three_lists_test;
	import sil_pkg::*;

	localparam int ITEM_TARGET = 1750;
	localparam int HOLD_CYCLES = 80;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;  // age[7:0], gender[9:8], list_select[11:10], position[17:12]
	logic [1:0]  s_tuser = OP_INSERT;  // operation[1:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;  // read_age[7:0], read_valid[8], list_count[15:9], insert_refused[16]
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_data = '0;

	int pending;
	int fail_count;

	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_requests = 0;
	int holds_done = 0;
	int hold_left = 0;
	int sent_count = 0;
	logic [7:0] current_adult = ADULT_AGE_RESET;

	sorted_insert_three_lists #(.LIST_DEPTH(64)) dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	age_list_checker #(.LIST_DEPTH(64)) chk (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.pending(pending), .fail_count(fail_count)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		#1000000;
		$display("*** FAILED ***");
		$finish;
	end

	// receiver: random stalls, plus a long counted hold-off on request
	always @(posedge clk) begin
		if (hold_left != 0) begin
			m_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (holds_done != hold_requests) begin
			m_tready <= 1'b0;
			hold_left <= HOLD_CYCLES;
			holds_done <= holds_done + 1;
		end else begin
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	task automatic send_cmd(input op_t op, input logic [7:0] age, input logic [1:0] gender,
			input logic [1:0] sel, input logic [5:0] pos);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {6'b0, pos, sel, gender, age};
		do @(posedge clk); while (!s_tready);
		sent_count++;
	endtask

	// stop offering and wait until every result transfer has come back
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic write_adult(input logic [7:0] v);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		current_adult = v;
	endtask

	function automatic logic [7:0] pick_age();
		case ($urandom_range(3))
			0: pick_age = 8'($urandom_range(255));
			1: pick_age = 8'($urandom_range(4) * 5);  // few values, many equals
			2: pick_age = current_adult + 8'($urandom_range(2)) - 8'd1;  // around threshold
			default: pick_age = $urandom_range(1) ? 8'd255 : 8'd0;
		endcase
	endfunction

	// usually starts from empty lists, then leans on one gender so that list can fill
	task automatic run_sequence();
		int len;
		int r;
		logic [1:0] fav;
		logic [1:0] g;
		len = $urandom_range(20, 160);
		fav = $urandom_range(1) ? GENDER_MALE : GENDER_FEMALE;
		if ($urandom_range(9) < 8)
			send_cmd(OP_CLEAR, 8'($urandom_range(255)), 2'($urandom_range(3)), 2'd0, 6'd0);
		for (int k = 0; k < len; k++) begin
			r = $urandom_range(99);
			if (r < 5) begin
				send_cmd(op_t'($urandom_range(2)), 8'($urandom_range(255)),
					2'($urandom_range(3)), 2'($urandom_range(2)), 6'($urandom_range(63)));
			end else if (r < 35) begin
				send_cmd(OP_READ, 8'($urandom_range(255)), 2'($urandom_range(3)),
					2'($urandom_range(2)),
					$urandom_range(1) ? 6'($urandom_range(15)) : 6'($urandom_range(63)));
			end else begin
				g = ($urandom_range(9) < 7) ? fav : 2'($urandom_range(3));
				send_cmd(OP_INSERT, pick_age(), g, 2'($urandom_range(3)),
					6'($urandom_range(63)));
			end
		end
	endtask

	task automatic set_idle_mode(input int mode);
		case (mode)
			0: begin send_idle_pct = 0;  stall_pct <= 0;  end
			1: begin send_idle_pct = 61; stall_pct <= 0;  end
			2: begin send_idle_pct = 0;  stall_pct <= 61; end
			default: begin send_idle_pct = 7; stall_pct <= 7; end
		endcase
	endtask

	initial begin
		logic [7:0] adult_plan [8];
		int goal;
		adult_plan = '{8'd0, 8'd255, 8'd37, 8'd1, 8'd20, 8'($urandom_range(255)), 8'd100, 8'd255};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset threshold of 20, both sides of it, equal ages, empty reads
		send_cmd(OP_INSERT, 8'd0,   GENDER_MALE,   SEL_MINORS, 6'd0);
		send_cmd(OP_INSERT, 8'd255, GENDER_FEMALE, SEL_MINORS, 6'd0);
		send_cmd(OP_INSERT, 8'd19,  2'd0,          SEL_MINORS, 6'd0);
		send_cmd(OP_INSERT, 8'd20,  2'd3,          SEL_MINORS, 6'd0);
		send_cmd(OP_INSERT, 8'd19,  GENDER_MALE,   SEL_MINORS, 6'd0);
		send_cmd(OP_INSERT, 8'd0,   GENDER_MALE,   SEL_MINORS, 6'd0);
		send_cmd(OP_INSERT, 8'd21,  GENDER_FEMALE, SEL_MINORS, 6'd0);
		send_cmd(OP_READ,   8'd0,   2'd0,          SEL_MINORS, 6'd0);
		send_cmd(OP_READ,   8'd0,   2'd0,          SEL_MINORS, 6'd3);
		send_cmd(OP_READ,   8'd0,   2'd0,          SEL_MINORS, 6'd4);
		send_cmd(OP_READ,   8'd0,   2'd0,          SEL_FEMALE, 6'd0);
		send_cmd(OP_READ,   8'd0,   2'd0,          SEL_FEMALE, 6'd1);
		send_cmd(OP_READ,   8'd0,   2'd0,          SEL_MALE,   6'd2);
		send_cmd(OP_READ,   8'd0,   2'd0,          SEL_MALE,   6'd63);
		send_cmd(OP_CLEAR,  8'd0,   2'd0,          SEL_MINORS, 6'd0);
		send_cmd(OP_READ,   8'd0,   2'd0,          SEL_MINORS, 6'd0);
		send_cmd(OP_READ,   8'd0,   2'd0,          SEL_MALE,   6'd0);
		send_cmd(OP_INSERT, 8'd5,   GENDER_FEMALE, SEL_MINORS, 6'd0);
		send_cmd(OP_READ,   8'd0,   2'd0,          SEL_FEMALE, 6'd0);

		// fill minors and male past full depth so inserts get refused
		write_adult(8'd255);
		send_cmd(OP_CLEAR, 8'd0, 2'd0, SEL_MINORS, 6'd0);
		for (int k = 0; k < 70; k++)
			send_cmd(OP_INSERT, 8'($urandom_range(255)), GENDER_MALE, SEL_MINORS, 6'd0);
		for (int k = 0; k < 64; k += 9)
			send_cmd(OP_READ, 8'd0, 2'd0, 2'($urandom_range(2)), 6'(k));
		send_cmd(OP_READ, 8'd0, 2'd0, SEL_MINORS, 6'd63);
		send_cmd(OP_READ, 8'd0, 2'd0, SEL_MALE, 6'd63);
		sent_count = 0;

		for (int ph = 0; ph < 8; ph++) begin
			write_adult(adult_plan[ph]);
			set_idle_mode(ph % 4);
			if (ph == 0 || ph == 4)
				hold_requests <= hold_requests + 1;
			goal = (ITEM_TARGET * (ph + 1)) / 8;
			while (sent_count < goal)
				run_sequence();
		end

		drain();
		repeat (4) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
